### rtl/hsrf_pkg.sv
package hsrf_pkg;

    localparam int unsigned CMD_DEPTH = 8;
    localparam int unsigned CMD_IDX_W = $clog2(CMD_DEPTH);

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Register window, byte addresses after bits 6-7 are cleared
    localparam logic [23:0] ADDR_CTRL   = 24'ha12000;
    localparam logic [23:0] ADDR_MEMMOD = 24'ha12002;
    localparam logic [23:0] ADDR_STAT   = 24'ha12004;
    localparam logic [23:0] ADDR_VECTOR = 24'ha12006;
    localparam logic [23:0] ADDR_STOPW  = 24'ha1200c;
    localparam logic [23:0] ADDR_FLAGS  = 24'ha1200e;
    localparam logic [23:0] ADDR_CMD_LO = 24'ha12010;
    localparam logic [23:0] ADDR_CMD_HI = 24'ha1201f;
    localparam logic [23:0] ADDR_XFR_LO = 24'ha12020;
    localparam logic [23:0] ADDR_XFR_HI = 24'ha1202f;
    localparam logic [23:0] ADDR_MIRROR = 24'h0000c0;

    localparam logic [7:0]  PROTECT_ALL = 8'hff;
    localparam logic [15:0] STAT_MASK   = 16'hc700;
    localparam logic [15:0] STOPW_MASK  = 16'h0fff;

    typedef struct packed {
        logic        cmd;
        logic        upper;
        logic        lower;
        logic [23:0] address;
        logic [15:0] bus_data;
        logic [3:0]  wram_status;
        logic        irq_pending_in;
        logic        irq_enable_in;
        logic [7:0]  sub_flags;
        logic [15:0] sub_side_word;
    } t_req;

    typedef struct packed {
        logic [15:0] read_data;
        logic        sub_run;
        logic        sub_bus_request;
        logic        sub_reset_pulse;
        logic        irq_raise;
        logic        wram_switch_set;
        logic        wram_request_set;
        logic [1:0]  prog_bank;
        logic [7:0]  prog_protect;
        logic [7:0]  main_flags;
    } t_rsp;

    // One-hot register select from the address decoder
    typedef struct packed {
        logic                 ctrl;
        logic                 memmod;
        logic                 stat;
        logic                 vector;
        logic                 stopw;
        logic                 flags;
        logic                 cmd;
        logic                 xfer;
        logic [CMD_IDX_W-1:0] cmd_idx;
    } t_dec;

endpackage

### rtl/hsrf_req_if.sv
interface hsrf_req_if;
    logic            valid;
    logic            ready;
    hsrf_pkg::t_req  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/hsrf_rsp_if.sv
interface hsrf_rsp_if;
    logic            valid;
    logic            ready;
    hsrf_pkg::t_rsp  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/hsrf_cfg_if.sv
interface hsrf_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/hsrf_decode.sv
module hsrf_decode (
    input  logic [23:0]    i_address,
    output hsrf_pkg::t_dec o_dec
);
    import hsrf_pkg::*;

    logic [23:0] addr;

    // Clear bits 6-7 so the upper part of the page mirrors the window
    assign addr = i_address & ~ADDR_MIRROR;

    always_comb begin
        o_dec.ctrl    = (addr == ADDR_CTRL);
        o_dec.memmod  = (addr == ADDR_MEMMOD);
        o_dec.stat    = (addr == ADDR_STAT);
        o_dec.vector  = (addr == ADDR_VECTOR);
        o_dec.stopw   = (addr == ADDR_STOPW);
        o_dec.flags   = (addr == ADDR_FLAGS);
        o_dec.cmd     = (addr >= ADDR_CMD_LO) && (addr <= ADDR_CMD_HI);
        o_dec.xfer    = (addr >= ADDR_XFR_LO) && (addr <= ADDR_XFR_HI);
        // odd addresses alias the even word
        o_dec.cmd_idx = addr[CMD_IDX_W:1];
    end

endmodule

### rtl/host_side_register_file.sv
// Host-side register window of a coprocessor gate array.
// i_req carries one 16-bit bus access per word: read or write, byte lanes,
// 24-bit address, write data, and the sub side status used for reads.
// o_rsp returns one word per access: the read value (bus data on writes and
// undecoded addresses), the control pulses caused by a write, and the current
// run, bus request, bank, protect and main flag values.
// i_cfg writes the attach bit; with it clear, reads echo bus data and writes
// change nothing. Write it only while no access is in flight.
// An accepted word is held in the input register, goes through the
// decode and update logic, and lands in the output register once the
// output register is empty or its word is being taken. Throughput is one
// access per cycle while o_rsp is not stalled; the input register and the
// output register each hold a word, so the block keeps taking input while
// one finished word waits. If o_rsp is stalled the output register holds,
// the input register fills, and i_req.ready drops until the receiver takes
// it.
// Reset clears the window registers and command words, sets the attach bit,
// and empties both stages.
module host_side_register_file (
    input  logic i_clk,
    input  logic i_rst_n,
    hsrf_req_if.sink   i_req,
    hsrf_rsp_if.source o_rsp,
    hsrf_cfg_if.sink   i_cfg
);
    import hsrf_pkg::*;

    logic        r_in_valid;
    t_req        r_req;
    logic        r_out_valid;
    t_rsp        r_rsp;
    t_rsp        n_rsp;

    logic        r_attached;
    logic        r_run, n_run;
    logic        r_request, n_request;
    logic [1:0]  r_bank, n_bank;
    logic [7:0]  r_protect, n_protect;
    logic [15:0] r_vector, n_vector;
    logic [7:0]  r_flag, n_flag;
    logic [15:0] r_cmd_words [CMD_DEPTH];
    logic [15:0] n_cmd_word;
    logic        cmd_we;

    t_dec        dec;
    logic        advance;
    logic        process;
    logic        forced;
    logic        is_rd, is_wr;
    logic        wmode, wsel, wsw, wreq, st_b0, st_b1;
    logic [15:0] data;

    hsrf_decode u_decode (
        .i_address (r_req.address),
        .o_dec     (dec)
    );

    assign advance     = !r_out_valid || o_rsp.ready;
    assign process     = r_in_valid && advance;
    assign i_req.ready = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_rsp;

    assign data  = r_req.bus_data;
    assign wmode = r_req.wram_status[0];
    assign wsel  = r_req.wram_status[1];
    assign wsw   = r_req.wram_status[2];
    assign wreq  = r_req.wram_status[3];
    assign st_b0 = wmode ? wsel : !wsw;
    assign st_b1 = wmode ? wreq : wsw;
    assign is_rd = r_attached && (r_req.cmd == CMD_READ);
    assign is_wr = r_attached && (r_req.cmd == CMD_WRITE);

    // Documented forced-reset write: leave run and request alone
    assign forced = r_request && !r_run && (data[1:0] == 2'b00) &&
                    (r_protect == PROTECT_ALL) && (r_bank == 2'b00) && wreq;

    always_comb begin
        n_run      = r_run;
        n_request  = r_request;
        n_bank     = r_bank;
        n_protect  = r_protect;
        n_vector   = r_vector;
        n_flag     = r_flag;
        n_cmd_word = r_cmd_words[dec.cmd_idx];
        cmd_we     = 1'b0;
        n_rsp      = '0;
        n_rsp.read_data = data;

        if (is_rd) begin
            unique if (dec.ctrl) begin
                n_rsp.read_data = {r_req.irq_enable_in, 6'b0, r_req.irq_pending_in,
                                   6'b0, r_request, r_run};
            end else if (dec.memmod) begin
                n_rsp.read_data = {r_protect, r_bank, 3'b0, wmode, st_b1, st_b0};
            end else if (dec.stat) begin
                n_rsp.read_data = r_req.sub_side_word & STAT_MASK;
            end else if (dec.vector) begin
                n_rsp.read_data = r_vector;
            end else if (dec.stopw) begin
                n_rsp.read_data = r_req.sub_side_word & STOPW_MASK;
            end else if (dec.flags) begin
                n_rsp.read_data = {r_flag, r_req.sub_flags};
            end else if (dec.cmd) begin
                n_rsp.read_data = r_cmd_words[dec.cmd_idx];
            end else if (dec.xfer) begin
                n_rsp.read_data = r_req.sub_side_word;
            end else begin
                // undecoded: echo bus data
                n_rsp.read_data = data;
            end
        end else if (is_wr) begin
            unique if (dec.ctrl) begin
                if (r_req.lower && !forced) begin
                    n_rsp.sub_reset_pulse = r_run && !data[0];
                    n_run     = data[0];
                    n_request = data[0] ? data[1] : 1'b1;
                end
                n_rsp.irq_raise = r_req.upper && data[8];
            end else if (dec.memmod) begin
                if (r_req.lower) begin
                    n_rsp.wram_switch_set  = data[1];
                    n_rsp.wram_request_set = !data[1];
                    n_bank = data[7:6];
                end
                if (r_req.upper) begin
                    n_protect = data[15:8];
                end
            end else if (dec.vector) begin
                if (r_req.upper) begin
                    n_vector[15:8] = data[15:8];
                end
                if (r_req.lower) begin
                    n_vector[7:0] = data[7:0];
                end
            end else if (dec.flags) begin
                n_flag = data[15:8];
            end else if (dec.cmd) begin
                cmd_we = r_req.upper || r_req.lower;
                if (r_req.upper) begin
                    n_cmd_word[15:8] = data[15:8];
                end
                if (r_req.lower) begin
                    n_cmd_word[7:0] = data[7:0];
                end
            end else begin
                // drop writes to read-only and undecoded addresses
                cmd_we = 1'b0;
            end
        end

        n_rsp.sub_run         = n_run;
        n_rsp.sub_bus_request = n_request;
        n_rsp.prog_bank       = n_bank;
        n_rsp.prog_protect    = n_protect;
        n_rsp.main_flags      = n_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_attached  <= 1'b1;
            r_run       <= 1'b0;
            r_request   <= 1'b0;
            r_bank      <= '0;
            r_protect   <= '0;
            r_vector    <= '0;
            r_flag      <= '0;
            for (int i = 0; i < CMD_DEPTH; i++) begin
                r_cmd_words[i] <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                r_attached <= i_cfg.data;
            end
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (process) begin
                r_run     <= n_run;
                r_request <= n_request;
                r_bank    <= n_bank;
                r_protect <= n_protect;
                r_vector  <= n_vector;
                r_flag    <= n_flag;
                if (cmd_we) begin
                    r_cmd_words[dec.cmd_idx] <= n_cmd_word;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req <= i_req.data;
        end
        if (process) begin
            r_rsp <= n_rsp;
        end
    end

    a_reset_pulse_clears_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_rsp.sub_reset_pulse |-> !r_rsp.sub_run)
        else $error("reset pulse with run still set");

    a_wram_pulses_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(n_rsp.wram_switch_set && n_rsp.wram_request_set))
        else $error("switch and request set together");

    a_read_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        process && (r_req.cmd == CMD_READ) |=>
            $stable(r_flag) && $stable(r_protect) && $stable(r_vector) && $stable(r_run))
        else $error("read changed register state");

    a_run_rises_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_run) |-> $past(process && is_wr && dec.ctrl))
        else $error("run set without a control write");

    a_run_clear_requests: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        process && is_wr && dec.ctrl && r_req.lower && !forced && !data[0] |=> r_request)
        else $error("run cleared without bus request");

endmodule

### verif/hsrf_scoreboard.sv
`timescale 1ns / 100ps

package hsrf_scoreboard_pkg;

    import hsrf_pkg::*;

    class window_scoreboard;

        // Predicted register window state
        bit          attached;
        bit          run_q;
        bit          request_q;
        logic [1:0]  bank_q;
        logic [7:0]  protect_q;
        logic [15:0] vector_q;
        logic [7:0]  flags_q;
        logic [15:0] command_q [CMD_DEPTH];

        t_rsp        expected_words [$];

        int unsigned errors;
        int unsigned accesses;
        int unsigned writes;
        int unsigned detached;
        int unsigned forced_hits;
        int unsigned reset_pulses;

        function new();
            attached  = 1'b1;
            run_q     = 1'b0;
            request_q = 1'b0;
            bank_q    = '0;
            protect_q = '0;
            vector_q  = '0;
            flags_q   = '0;
            foreach (command_q[i]) command_q[i] = '0;
        endfunction

        function void set_attach(bit value);
            attached = value;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // Predict the word for one accepted access and queue it
        function void note_access(t_req r);
            t_rsp        w;
            logic [23:0] addr;
            logic [15:0] d;
            logic [3:0]  ws;
            int unsigned slot;
            bit          forced;
            addr = r.address & ~ADDR_MIRROR;
            d    = r.bus_data;
            ws   = r.wram_status;
            slot = ((addr - ADDR_CMD_LO) >> 1) % CMD_DEPTH;
            w = '0;
            w.read_data = d;
            accesses++;
            if (!attached) begin
                detached++;
            end else if (r.cmd == CMD_READ) begin
                if (addr == ADDR_CTRL) begin
                    w.read_data     = '0;
                    w.read_data[0]  = run_q;
                    w.read_data[1]  = request_q;
                    w.read_data[8]  = r.irq_pending_in;
                    w.read_data[15] = r.irq_enable_in;
                end else if (addr == ADDR_MEMMOD) begin
                    w.read_data        = '0;
                    w.read_data[0]     = ws[0] ? ws[1] : ~ws[2];
                    w.read_data[1]     = ws[0] ? ws[3] : ws[2];
                    w.read_data[2]     = ws[0];
                    w.read_data[7:6]   = bank_q;
                    w.read_data[15:8]  = protect_q;
                end else if (addr == ADDR_STAT) begin
                    w.read_data = r.sub_side_word & STAT_MASK;
                end else if (addr == ADDR_VECTOR) begin
                    w.read_data = vector_q;
                end else if (addr == ADDR_STOPW) begin
                    w.read_data = r.sub_side_word & STOPW_MASK;
                end else if (addr == ADDR_FLAGS) begin
                    w.read_data = {flags_q, r.sub_flags};
                end else if (addr >= ADDR_CMD_LO && addr <= ADDR_CMD_HI) begin
                    w.read_data = command_q[slot];
                end else if (addr >= ADDR_XFR_LO && addr <= ADDR_XFR_HI) begin
                    w.read_data = r.sub_side_word;
                end
            end else begin
                writes++;
                if (addr == ADDR_CTRL) begin
                    if (r.lower) begin
                        forced = request_q && !run_q && d[1:0] == 2'b00 &&
                                 protect_q == PROTECT_ALL && bank_q == 2'd0 && ws[3];
                        if (forced) begin
                            forced_hits++;
                        end else begin
                            if (run_q && !d[0]) begin
                                w.sub_reset_pulse = 1'b1;
                                reset_pulses++;
                            end
                            run_q     = d[0];
                            request_q = run_q ? d[1] : 1'b1;
                        end
                    end
                    if (r.upper && d[8]) w.irq_raise = 1'b1;
                end else if (addr == ADDR_MEMMOD) begin
                    if (r.lower) begin
                        if (d[1]) w.wram_switch_set = 1'b1;
                        else w.wram_request_set = 1'b1;
                        bank_q = d[7:6];
                    end
                    if (r.upper) protect_q = d[15:8];
                end else if (addr == ADDR_VECTOR) begin
                    if (r.upper) vector_q[15:8] = d[15:8];
                    if (r.lower) vector_q[7:0] = d[7:0];
                end else if (addr == ADDR_FLAGS) begin
                    // high byte lands whatever the lanes say
                    flags_q = d[15:8];
                end else if (addr >= ADDR_CMD_LO && addr <= ADDR_CMD_HI) begin
                    if (r.lower) command_q[slot][7:0] = d[7:0];
                    if (r.upper) command_q[slot][15:8] = d[15:8];
                end
            end
            w.sub_run         = run_q;
            w.sub_bus_request = request_q;
            w.prog_bank       = bank_q;
            w.prog_protect    = protect_q;
            w.main_flags      = flags_q;
            expected_words.push_back(w);
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_word(t_rsp got);
            t_rsp want;
            if (expected_words.size() == 0) begin
                $error("result word 0x%0h with no access outstanding", got);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("sub_run", want.sub_run, got.sub_run);
            compare_field("sub_bus_request", want.sub_bus_request, got.sub_bus_request);
            compare_field("sub_reset_pulse", want.sub_reset_pulse, got.sub_reset_pulse);
            compare_field("irq_raise", want.irq_raise, got.irq_raise);
            compare_field("wram_switch_set", want.wram_switch_set, got.wram_switch_set);
            compare_field("wram_request_set", want.wram_request_set, got.wram_request_set);
            compare_field("prog_bank", want.prog_bank, got.prog_bank);
            compare_field("prog_protect", want.prog_protect, got.prog_protect);
            compare_field("main_flags", want.main_flags, got.main_flags);
        endfunction

    endclass

endpackage

### verif/host_side_register_file_test.sv
`timescale 1ns / 100ps

module host_side_register_file_test;

    import hsrf_pkg::*;
    import hsrf_scoreboard_pkg::*;

    logic i_clk;
    logic i_rst_n;

    hsrf_req_if req_bus ();
    hsrf_rsp_if rsp_bus ();
    hsrf_cfg_if cfg_bus ();

    window_scoreboard sb;

    bit sender_steady;
    bit receiver_steady;
    int hold_left;

    host_side_register_file dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .i_cfg   (cfg_bus)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Receiver: random stalls, or a long hold-off counted here
    initial begin
        rsp_bus.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                rsp_bus.ready <= 1'b0;
                hold_left--;
            end else begin
                rsp_bus.ready <= receiver_steady || ($urandom_range(99) >= 37);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_bus.valid && req_bus.ready) sb.note_access(req_bus.data);
            if (rsp_bus.valid && rsp_bus.ready) sb.check_word(rsp_bus.data);
        end
    end

    function automatic t_req build_access(logic cmd, logic up, logic lo, logic [23:0] addr,
                                          logic [15:0] data, logic [3:0] ws);
        t_req r;
        r.cmd            = cmd;
        r.upper          = up;
        r.lower          = lo;
        r.address        = addr;
        r.bus_data       = data;
        r.wram_status    = ws;
        r.irq_pending_in = 1'($urandom_range(1));
        r.irq_enable_in  = 1'($urandom_range(1));
        r.sub_flags      = 8'($urandom);
        r.sub_side_word  = 16'($urandom);
        return r;
    endfunction

    function automatic t_req random_access();
        t_req        r;
        int unsigned pick;
        logic [23:0] addr;
        logic [15:0] data;
        pick = $urandom_range(99);
        if (pick < 14) addr = ADDR_CTRL;
        else if (pick < 26) addr = ADDR_MEMMOD;
        else if (pick < 32) addr = ADDR_STAT;
        else if (pick < 42) addr = ADDR_VECTOR;
        else if (pick < 47) addr = ADDR_STOPW;
        else if (pick < 57) addr = ADDR_FLAGS;
        else if (pick < 77) addr = ADDR_CMD_LO + 24'($urandom_range(15));
        else if (pick < 85) addr = ADDR_XFR_LO + 24'($urandom_range(15));
        else if (pick < 93) addr = {16'ha120, 8'($urandom)};
        else addr = 24'($urandom);
        if (pick < 57 && $urandom_range(9) == 0) addr[0] = 1'b1;
        if (pick < 85) addr[7:6] = 2'($urandom_range(3));
        data = 16'($urandom);
        // bias toward the values that reach the forced reset sequence
        if ($urandom_range(3) == 0) data[1:0] = 2'b00;
        if ($urandom_range(3) == 0) data[15:8] = PROTECT_ALL;
        if ($urandom_range(3) == 0) data[7:6] = 2'b00;
        r = build_access($urandom_range(1) ? CMD_WRITE : CMD_READ,
                         $urandom_range(3) != 0, $urandom_range(3) != 0,
                         addr, data, 4'($urandom));
        return r;
    endfunction

    // Entered and left at a falling edge
    task automatic send_access(t_req r);
        while (!sender_steady && $urandom_range(99) < 37) begin
            req_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.data  <= r;
        do @(posedge i_clk); while (!req_bus.ready);
        @(negedge i_clk);
    endtask

    task automatic send_random(int count);
        repeat (count) send_access(random_access());
    endtask

    task automatic drain();
        req_bus.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_attach(bit value);
        drain();
        repeat (4) @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= value;
        do @(posedge i_clk); while (!cfg_bus.ready);
        sb.set_attach(value);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    initial begin
        sb = new();
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
        hold_left       = 0;
        i_rst_n       <= 1'b0;
        req_bus.valid <= 1'b0;
        req_bus.data  <= '0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.data  <= 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: run/reset/irq, forced reset, word-RAM, every register
        send_access(build_access(CMD_READ,  1'b1, 1'b1, ADDR_CTRL,   16'h0000, 4'h0));
        send_access(build_access(CMD_WRITE, 1'b0, 1'b1, ADDR_CTRL,   16'h0001, 4'h0));
        send_access(build_access(CMD_WRITE, 1'b1, 1'b1, ADDR_CTRL,   16'h0100, 4'h0));
        send_access(build_access(CMD_WRITE, 1'b1, 1'b1, ADDR_MEMMOD, 16'hff02, 4'h0));
        send_access(build_access(CMD_WRITE, 1'b0, 1'b1, ADDR_CTRL,   16'h0000, 4'h8));
        send_access(build_access(CMD_WRITE, 1'b0, 1'b1, ADDR_CTRL,   16'h0003, 4'h8));
        send_access(build_access(CMD_WRITE, 1'b0, 1'b1, ADDR_MEMMOD, 16'h00c0, 4'h0));
        send_access(build_access(CMD_READ,  1'b1, 1'b1, ADDR_MEMMOD, 16'h0000, 4'h5));
        send_access(build_access(CMD_READ,  1'b1, 1'b1, ADDR_MEMMOD, 16'h0000, 4'ha));
        send_access(build_access(CMD_WRITE, 1'b1, 1'b0, ADDR_VECTOR, 16'habcd, 4'h0));
        send_access(build_access(CMD_WRITE, 1'b0, 1'b1, ADDR_VECTOR, 16'h1234, 4'h0));
        send_access(build_access(CMD_READ,  1'b1, 1'b1, ADDR_VECTOR, 16'h0000, 4'h0));
        send_access(build_access(CMD_WRITE, 1'b0, 1'b0, ADDR_FLAGS,  16'ha5ff, 4'h0));
        send_access(build_access(CMD_READ,  1'b1, 1'b1, ADDR_FLAGS,  16'h0000, 4'h0));
        send_access(build_access(CMD_WRITE, 1'b1, 1'b1, ADDR_CMD_LO, 16'hffff, 4'h0));
        send_access(build_access(CMD_WRITE, 1'b0, 1'b1, ADDR_CMD_HI, 16'h0055, 4'h0));
        send_access(build_access(CMD_READ,  1'b1, 1'b1, ADDR_CMD_HI - 24'd1, 16'h0000, 4'h0));
        send_access(build_access(CMD_READ,  1'b1, 1'b1, ADDR_CMD_LO + 24'd1, 16'h0000, 4'h0));
        send_access(build_access(CMD_READ,  1'b1, 1'b1, ADDR_STAT,   16'h0000, 4'h0));
        send_access(build_access(CMD_READ,  1'b1, 1'b1, ADDR_STOPW,  16'h0000, 4'h0));
        send_access(build_access(CMD_READ,  1'b1, 1'b1, ADDR_XFR_HI, 16'h0000, 4'h0));
        send_access(build_access(CMD_READ,  1'b1, 1'b1, ADDR_CTRL | ADDR_MIRROR,
                                 16'h0000, 4'h0));
        send_access(build_access(CMD_READ,  1'b1, 1'b1, ADDR_CTRL + 24'd1, 16'hbeef, 4'h0));
        send_access(build_access(CMD_READ,  1'b1, 1'b1, 24'hffffff,  16'hffff, 4'hf));
        send_access(build_access(CMD_WRITE, 1'b1, 1'b1, 24'h000000,  16'hffff, 4'hf));

        write_attach(1'b0);
        send_random(30);
        write_attach(1'b1);
        send_random(700);

        // Hold the receiver off while the sender keeps offering
        sender_steady = 1'b1;
        hold_left = 80;
        send_random(120);

        receiver_steady = 1'b1;
        send_random(300);
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;

        drain();
        send_random(600);

        write_attach(1'b0);
        send_random(50);
        write_attach(1'b1);
        send_random(60);

        drain();
        repeat (10) @(negedge i_clk);

        $display("Covered %0d accesses: %0d writes, %0d while detached.",
                 sb.accesses, sb.writes, sb.detached);
        $display("Forced reset sequence ignored %0d times, %0d sub reset pulses seen.",
                 sb.forced_hits, sb.reset_pulses);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### files.f
rtl/hsrf_pkg.sv
rtl/hsrf_req_if.sv
rtl/hsrf_rsp_if.sv
rtl/hsrf_cfg_if.sv
rtl/hsrf_decode.sv
rtl/host_side_register_file.sv
verif/hsrf_scoreboard.sv
verif/host_side_register_file_test.sv
